### src/edist_pkg.sv
package edist_pkg;

  // String buffer size and derived widths
  localparam int MAX_LEN   = 64;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);  // 0..MAX_LEN
  localparam int CIDX_W    = $clog2(MAX_LEN);      // index into character buffer
  localparam int COST_W    = LEN_W;                // row entries never exceed MAX_LEN
  localparam int CHAR_W    = 8;
  localparam int DIST_W    = 7;

  // Input tuser bits
  localparam int USER_CMD = 0;
  localparam int USER_HAS = 1;

  // cmd codes
  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for an item
    ST_INIT,   // writing row 0..m
    ST_ROW,    // rewriting the row for one character
    ST_RD,     // reading row[m]
    ST_EMIT    // loading the result register
  } state_t;

endpackage

### src/edist_ram.sv
module edist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/edit_distance_engine_top.sv
// Levenshtein distance engine, first string of m characters buffered in a RAM.
// First-string items are stored while the engine stays idle. A second-string item, once accepted,
// seeds the row in ST_INIT (first item of a string only), then makes one ST_ROW pass per character
// (one row entry per cycle through the cost RAM's ports); input stays low meanwhile. On the last
// item the result passes ST_RD and ST_EMIT into out_tvalid; input reopens then, unless an earlier
// result still waits in the output register. rst_n (synchronous, active low) clears control state.
module edit_distance_engine_top
  import edist_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic [1:0] in_tuser,   // [0] cmd, [1] has_char
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] distance, [7] zero
  output logic       out_tuser   // [0] overflow
);

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [LEN_W-1:0]  second_cnt_r, second_cnt_nxt;
  logic              first_open_r, first_open_nxt;
  logic              in_second_r, in_second_nxt;
  logic              too_long_r, too_long_nxt;
  logic              second_over_r, second_over_nxt;

  // Current second-string item
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic              last_r, last_nxt;
  logic              do_char_r, do_char_nxt;

  // Row pass pipeline
  logic [LEN_W-1:0]  idx_r, idx_nxt;        // init write index / read issue index
  logic              rd_active_r, rd_active_nxt;
  logic              wb_vld_r, wb_vld_nxt;
  logic [LEN_W-1:0]  wb_idx_r, wb_idx_nxt;
  logic [COST_W-1:0] diag_r, diag_nxt;
  logic [COST_W-1:0] prev_r, prev_nxt;

  // Result register
  logic              out_vld_r, out_vld_nxt;
  logic [DIST_W-1:0] dist_r, dist_nxt;
  logic              ovf_r, ovf_nxt;

  // RAM ports
  logic              fc_wr_en;
  logic [CIDX_W-1:0] fc_wr_addr;
  logic              fc_rd_en;
  logic [CIDX_W-1:0] fc_rd_addr;
  logic [CHAR_W-1:0] fc_rd_data;

  logic              row_wr_en;
  logic [LEN_W-1:0]  row_wr_addr;
  logic [COST_W-1:0] row_wr_data;
  logic              row_rd_en;
  logic [LEN_W-1:0]  row_rd_addr;
  logic [COST_W-1:0] row_rd_data;

  // Input decode
  logic              in_fire;
  logic              in_cmd;
  logic              in_has;
  logic [LEN_W-1:0]  cnt_eff;
  logic              init_needed;
  logic              char_ok;

  // Cell update
  logic [COST_W-1:0] min_lp;
  logic [COST_W-1:0] min_all;
  logic [COST_W-1:0] cell_val;

  edist_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_chars (
    .clk     (clk),
    .wr_en   (fc_wr_en),
    .wr_addr (fc_wr_addr),
    .wr_data (in_tdata),
    .rd_en   (fc_rd_en),
    .rd_addr (fc_rd_addr),
    .rd_data (fc_rd_data)
  );

  edist_ram #(.WIDTH(COST_W), .DEPTH(ROW_DEPTH)) u_row_costs (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_cmd     = in_tuser[USER_CMD];
  assign in_has     = in_tuser[USER_HAS];

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(8 - DIST_W){1'b0}}, dist_r};
  assign out_tuser  = ovf_r;

  // Second-string bookkeeping for the item at the input
  assign init_needed = !in_second_r;
  assign cnt_eff     = init_needed ? '0 : second_cnt_r;
  assign char_ok     = (cnt_eff < LEN_W'(MAX_LEN));

  // One row cell: match takes diag, else 1 + min of left, up, diag
  assign min_lp    = (row_rd_data < prev_r) ? row_rd_data : prev_r;
  assign min_all   = (diag_r < min_lp) ? diag_r : min_lp;
  assign cell_val  = (fc_rd_data == ch_r) ? diag_r : COST_W'(min_all + COST_W'(1));

  // Character buffer read tracks the row read, one entry behind
  assign fc_rd_addr = CIDX_W'(idx_r - LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_len_r   <= '0;
      second_cnt_r  <= '0;
      first_open_r  <= 1'b0;
      in_second_r   <= 1'b0;
      too_long_r    <= 1'b0;
      second_over_r <= 1'b0;
      rd_active_r   <= 1'b0;
      wb_vld_r      <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      first_len_r   <= first_len_nxt;
      second_cnt_r  <= second_cnt_nxt;
      first_open_r  <= first_open_nxt;
      in_second_r   <= in_second_nxt;
      too_long_r    <= too_long_nxt;
      second_over_r <= second_over_nxt;
      rd_active_r   <= rd_active_nxt;
      wb_vld_r      <= wb_vld_nxt;
      out_vld_r     <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    last_r    <= last_nxt;
    do_char_r <= do_char_nxt;
    idx_r     <= idx_nxt;
    wb_idx_r  <= wb_idx_nxt;
    diag_r    <= diag_nxt;
    prev_r    <= prev_nxt;
    dist_r    <= dist_nxt;
    ovf_r     <= ovf_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    first_len_nxt   = first_len_r;
    second_cnt_nxt  = second_cnt_r;
    first_open_nxt  = first_open_r;
    in_second_nxt   = in_second_r;
    too_long_nxt    = too_long_r;
    second_over_nxt = second_over_r;
    ch_nxt          = ch_r;
    last_nxt        = last_r;
    do_char_nxt     = do_char_r;
    idx_nxt         = idx_r;
    rd_active_nxt   = rd_active_r;
    wb_vld_nxt      = 1'b0;
    wb_idx_nxt      = idx_r;
    diag_nxt        = diag_r;
    prev_nxt        = prev_r;
    out_vld_nxt     = out_vld_r;
    dist_nxt        = dist_r;
    ovf_nxt         = ovf_r;

    fc_wr_en    = 1'b0;
    fc_wr_addr  = CIDX_W'(first_len_r);
    fc_rd_en    = 1'b0;
    row_wr_en   = 1'b0;
    row_wr_addr = idx_r;
    row_wr_data = COST_W'(idx_r);
    row_rd_en   = 1'b0;
    row_rd_addr = idx_r;

    // Result taken downstream
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_FIRST) begin
            // First-string item: store the character in place
            if (!first_open_r) begin
              first_len_nxt  = '0;
              too_long_nxt   = 1'b0;
              in_second_nxt  = 1'b0;
            end
            fc_wr_addr = first_open_r ? CIDX_W'(first_len_r) : '0;
            if (in_has) begin
              if (!first_open_r || first_len_r < LEN_W'(MAX_LEN)) begin
                fc_wr_en      = 1'b1;
                first_len_nxt = (first_open_r ? first_len_r : '0) + LEN_W'(1);
              end else begin
                too_long_nxt = 1'b1;
              end
            end
            first_open_nxt = !in_tlast;
          end else begin
            // Second-string item
            first_open_nxt = 1'b0;
            in_second_nxt  = !in_tlast;
            ch_nxt         = in_tdata;
            last_nxt       = in_tlast;
            do_char_nxt    = in_has && char_ok;
            if (init_needed) begin
              second_cnt_nxt  = '0;
              second_over_nxt = in_has && !char_ok;
            end else if (in_has && !char_ok) begin
              second_over_nxt = 1'b1;
            end
            idx_nxt       = '0;
            rd_active_nxt = 1'b1;
            if (init_needed) begin
              state_nxt = ST_INIT;
            end else if (in_has && char_ok) begin
              state_nxt = ST_ROW;
            end else if (in_tlast) begin
              state_nxt = ST_RD;
            end
          end
        end
      end

      ST_INIT: begin
        // row[i] = i for i in 0..m
        row_wr_en   = 1'b1;
        row_wr_addr = idx_r;
        row_wr_data = COST_W'(idx_r);
        idx_nxt     = idx_r + LEN_W'(1);
        if (idx_r == first_len_r) begin
          idx_nxt       = '0;
          rd_active_nxt = 1'b1;
          if (do_char_r) begin
            state_nxt = ST_ROW;
          end else if (last_r) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_ROW: begin
        // Issue reads of row[idx] and first_chars[idx-1]
        if (rd_active_r) begin
          row_rd_en   = 1'b1;
          row_rd_addr = idx_r;
          fc_rd_en    = 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_idx_nxt  = idx_r;
          idx_nxt     = idx_r + LEN_W'(1);
          if (idx_r == first_len_r) begin
            rd_active_nxt = 1'b0;
          end
        end
        // Write back one cell per cycle; write index always trails read index
        if (wb_vld_r) begin
          row_wr_en   = 1'b1;
          row_wr_addr = wb_idx_r;
          diag_nxt    = row_rd_data;
          if (wb_idx_r == '0) begin
            row_wr_data = COST_W'(second_cnt_r + LEN_W'(1));
            prev_nxt    = COST_W'(second_cnt_r + LEN_W'(1));
          end else begin
            row_wr_data = cell_val;
            prev_nxt    = cell_val;
          end
          if (wb_idx_r == first_len_r) begin
            second_cnt_nxt = second_cnt_r + LEN_W'(1);
            if (last_r) begin
              state_nxt = ST_RD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end

      ST_RD: begin
        // Fetch row[m] for the result
        row_rd_en   = 1'b1;
        row_rd_addr = first_len_r;
        state_nxt   = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          ovf_nxt     = too_long_r || second_over_r;
          dist_nxt    = (too_long_r || second_over_r) ? '0 : DIST_W'(row_rd_data);
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### dv/tb.sv
module tb;
  import edist_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS     = 1250;
  localparam int CALM_ITEMS  = 150;   // no idling for the last items of the run
  localparam int HOLD_AT     = 300;   // item count that triggers the long receiver hold-off
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 700;   // item count where the sender waits for all results
  localparam int STALL_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int TAIL_CYCLES = 2 * MAX_LEN + 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] ch
  logic [1:0] in_tuser = '0;   // [0] cmd, [1] has_char
  logic       in_tlast = 1'b0; // last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [6:0] distance, [7] zero
  logic       out_tuser;       // [0] overflow

  edit_distance_engine_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } dist_rec_t;

  // directed row: item fields, then an optional typed-in result
  typedef struct packed {
    logic              cmd;
    logic              has;
    logic [7:0]        ch;
    logic              last;
    logic              known;
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } stim_row_t;

  dist_rec_t pending_dist[$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        stall_cycles = 0;
  bit        calm = 1'b0;
  int        gap_pct = 20;
  dist_rec_t got_exp;

  // Shadow copy of the engine state
  logic [7:0]  a_chars [MAX_LEN];
  int unsigned a_len = 0;
  int unsigned cost_row [MAX_LEN + 1];
  int unsigned b_count = 0;
  bit          b_active = 1'b0;
  bit          a_over = 1'b0;
  bit          a_open = 1'b0;
  bit          b_over = 1'b0;

  // Returns 1 when the item closes a second string; res then holds the distance
  function automatic bit predict_distance(input logic cmd, input logic has,
                                          input logic [7:0] ch, input logic last,
                                          output dist_rec_t res);
    int unsigned diag, left, nxt, best;
    res = '0;
    if (cmd == CMD_FIRST) begin
      // a new first string drops the stored one and any second string in progress
      if (!a_open) begin
        a_len    = 0;
        a_over   = 1'b0;
        a_open   = 1'b1;
        b_active = 1'b0;
      end
      if (has) begin
        if (a_len < MAX_LEN) begin
          a_chars[a_len] = ch;
          a_len++;
        end else begin
          a_over = 1'b1;
        end
      end
      if (last) a_open = 1'b0;
      return 1'b0;
    end
    // start of a second string: seed the row with 0..m
    if (!b_active) begin
      a_open = 1'b0;
      for (int i = 0; i <= a_len; i++) cost_row[i] = i;
      b_count  = 0;
      b_over   = 1'b0;
      b_active = 1'b1;
    end
    if (has) begin
      if (b_count < MAX_LEN) begin
        diag = cost_row[0];
        cost_row[0] = b_count + 1;
        for (int i = 1; i <= a_len; i++) begin
          left = cost_row[i];
          if (a_chars[i-1] == ch) begin
            nxt = diag;
          end else begin
            best = left;
            if (cost_row[i-1] < best) best = cost_row[i-1];
            if (diag < best) best = diag;
            nxt = best + 1;
          end
          diag = left;
          cost_row[i] = nxt;
        end
        b_count++;
      end else begin
        b_over = 1'b1;
      end
    end
    if (last) begin
      res.ovf      = a_over || b_over;
      res.distance = res.ovf ? '0 : DIST_W'(cost_row[a_len]);
      b_active     = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item, wait for it to be taken, then record what it should produce
  task automatic put_item(input logic cmd, input logic has, input logic [7:0] ch,
                          input logic last, input logic known = 1'b0,
                          input logic [DIST_W-1:0] k_dist = '0, input logic k_ovf = 1'b0);
    logic [1:0] user;
    dist_rec_t  res;
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    user           = '0;
    user[USER_CMD] = cmd;
    user[USER_HAS] = has;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= user;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (items_sent >= N_ITEMS - CALM_ITEMS) calm = 1'b1;
    if (predict_distance(cmd, has, ch, last, res)) begin
      if (known) begin
        res.distance = k_dist;
        res.ovf      = k_ovf;
      end
      pending_dist = {pending_dist, res};
    end
  endtask

  function automatic logic [7:0] pick_char(input bit wide);
    if (wide) return 8'($urandom_range(0, 255));
    return 8'h61 + 8'($urandom_range(0, 3));
  endfunction

  // mostly short strings, some medium, a few near or past the buffer size
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return $urandom_range(0, 8);
    if (r < 92) return $urandom_range(9, 40);
    return $urandom_range(MAX_LEN - 4, MAX_LEN + 3);
  endfunction

  // Well-formed string, with optional opening, interleaved and trailing empty items
  task automatic send_string(input logic cmd, input int len, input bit wide);
    bit tail;
    tail = (len > 0) && ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0) put_item(cmd, 1'b0, pick_char(1'b1), 1'b0);
    if (len == 0) put_item(cmd, 1'b0, pick_char(1'b1), 1'b1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 15) == 0) put_item(cmd, 1'b0, pick_char(1'b1), 1'b0);
      put_item(cmd, 1'b1, pick_char(wide), (k == len - 1) && !tail);
    end
    if (tail) put_item(cmd, 1'b0, pick_char(1'b1), 1'b1);
  endtask

  // Directed opening: empty strings, byte extremes, matches, abandoned strings
  stim_row_t opening_rows [0:20] = '{
    '{CMD_SECOND, 1'b0, 8'h00, 1'b1, 1'b1, 7'd0, 1'b0}, // empty vs nothing loaded
    '{CMD_SECOND, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'hFF, 1'b1, 1'b1, 7'd2, 1'b0}, // no first string: distance n
    '{CMD_FIRST,  1'b1, 8'h61, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_FIRST,  1'b1, 8'h62, 1'b1, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h61, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h62, 1'b1, 1'b1, 7'd0, 1'b0}, // identical strings
    '{CMD_SECOND, 1'b0, 8'h00, 1'b1, 1'b1, 7'd2, 1'b0}, // empty second string
    '{CMD_SECOND, 1'b1, 8'h78, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h62, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h79, 1'b1, 1'b0, 7'd0, 1'b0},
    '{CMD_FIRST,  1'b0, 8'h00, 1'b1, 1'b0, 7'd0, 1'b0}, // empty first string
    '{CMD_SECOND, 1'b1, 8'h71, 1'b1, 1'b1, 7'd1, 1'b0},
    '{CMD_FIRST,  1'b0, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0}, // opens, no character
    '{CMD_FIRST,  1'b1, 8'h6B, 1'b0, 1'b0, 7'd0, 1'b0}, // first left open
    '{CMD_SECOND, 1'b1, 8'h6B, 1'b1, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h61, 1'b0, 1'b0, 7'd0, 1'b0}, // second in progress...
    '{CMD_FIRST,  1'b1, 8'h7A, 1'b1, 1'b0, 7'd0, 1'b0}, // ...abandoned by new first
    '{CMD_SECOND, 1'b1, 8'h7A, 1'b1, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b1, 8'h00, 1'b0, 1'b0, 7'd0, 1'b0},
    '{CMD_SECOND, 1'b0, 8'h00, 1'b1, 1'b0, 7'd0, 1'b0}  // closed by an empty item
  };

  // Stimulus
  initial begin
    int  r;
    bit  drained;
    drained = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i])
      put_item(opening_rows[i].cmd, opening_rows[i].has, opening_rows[i].ch,
               opening_rows[i].last, opening_rows[i].known, opening_rows[i].distance,
               opening_rows[i].ovf);

    // full-size strings, then overflow on each side
    send_string(CMD_FIRST, MAX_LEN, 1'b1);
    send_string(CMD_SECOND, MAX_LEN, 1'b1);
    send_string(CMD_SECOND, MAX_LEN + 1, 1'b0);
    send_string(CMD_FIRST, MAX_LEN + 1, 1'b0);
    send_string(CMD_SECOND, 1, 1'b0);
    send_string(CMD_SECOND, 0, 1'b0);

    while (items_sent < N_ITEMS) begin
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      if (!drained && items_sent >= DRAIN_AT) begin
        // sender pause until the engine has handed back everything
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_dist.size() != 0);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 28) begin
        send_string(CMD_FIRST, pick_len(), $urandom_range(0, 3) == 0);
      end else if (r < 82) begin
        send_string(CMD_SECOND, pick_len(), $urandom_range(0, 3) == 0);
      end else if (r < 88) begin
        // second string cut short by a new first string
        if ($urandom_range(0, 3) == 0) put_item(CMD_SECOND, 1'b0, pick_char(1'b1), 1'b0);
        else repeat ($urandom_range(1, 3)) put_item(CMD_SECOND, 1'b1, pick_char(1'b0), 1'b0);
        send_string(CMD_FIRST, pick_len(), 1'b0);
      end else if (r < 94) begin
        // first string left open when the second begins
        repeat ($urandom_range(1, 4)) put_item(CMD_FIRST, 1'b1, pick_char(1'b0), 1'b0);
        send_string(CMD_SECOND, pick_len(), 1'b0);
      end else begin
        // noise
        repeat ($urandom_range(1, 6))
          put_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_char(1'b1),
                   1'($urandom_range(0, 1)));
      end
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_dist.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_dist.size() != 0) report_mismatch("results never delivered",
                                                  0, pending_dist.size());
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, always ready near the end
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && items_sent >= HOLD_AT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end else if (calm || $urandom_range(0, 99) < 65) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_dist.size() == 0) begin
        report_mismatch("result with none pending, distance", out_tdata, 0);
      end else begin
        got_exp = pending_dist.pop_front();
        if (out_tdata !== {1'b0, got_exp.distance})
          report_mismatch("distance", out_tdata, got_exp.distance);
        if (out_tuser !== got_exp.ovf)
          report_mismatch("overflow", out_tuser, got_exp.ovf);
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

endmodule

### filelist.f
src/edist_pkg.sv
src/edist_ram.sv
src/edit_distance_engine_top.sv
dv/tb.sv
